// ===== rtl/core/sensor_frame_deframer_top_macros.svh =====
// assertion macros shared by the deframer checker
// no dependencies; included by files that hold concurrent assertions
`ifndef SENSOR_FRAME_DEFRAMER_TOP_MACROS_SVH
`define SENSOR_FRAME_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SFD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, disabled while reset is asserted
`define SFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

// next-cycle implication that also holds across reset
`define SFD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ===== rtl/core/sfd_pkg.sv =====
// types and constants of the sensor frame deframer
// no dependencies; used by sfd_parser and sensor_frame_deframer_top
package sfd_pkg;

  // parse phases
  localparam logic [3:0] PH_HUNT = 4'd0;
  localparam logic [3:0] PH_FUNC = 4'd1;
  localparam logic [3:0] PH_SIZE = 4'd2;
  localparam logic [3:0] PH_PAY0 = 4'd3;
  localparam logic [3:0] PH_CSUM = 4'd15;

  // frame constants
  localparam logic [7:0] FRAME_SIZE = 8'd12;
  localparam int         NUM_WORDS  = 6;

  // configuration register indexes and reset values
  localparam logic [1:0] REG_HEADER_BYTE   = 2'd0;
  localparam logic [1:0] REG_FUNCTION_CODE = 2'd1;
  localparam logic [1:0] REG_CHECK_ENABLE  = 2'd2;
  localparam logic [7:0] HEADER_RESET      = 8'h64;
  localparam logic [7:0] FUNCTION_RESET    = 8'h01;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] function_code;
    logic       check_enable;
  } cfg_t;

  typedef struct packed {
    logic [15:0] left_range;
    logic [15:0] right_range;
    logic [15:0] front_ball;
    logic [15:0] left_ball;
    logic [15:0] right_ball;
    logic [15:0] rear_ball;
    logic        checksum_match;
    logic        accepted;
  } frame_t;

endpackage

// ===== rtl/core/sfd_parser.sv =====
// byte-wise frame parser: phase tracking, word collection and running xor
// depends on sfd_pkg
module sfd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_take,
  input  logic [7:0]    rx_byte,
  input  sfd_pkg::cfg_t cfg,
  output logic          at_checksum,
  output logic          frame_done,
  output sfd_pkg::frame_t frame
);

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] word_r [sfd_pkg::NUM_WORDS];
  logic [7:0]  low_r;
  logic [7:0]  xor_r;
  logic [3:0]  pay_pos;
  logic [2:0]  word_idx;
  logic [3:0]  hunt_ph;
  logic        match;

  assign pay_pos  = phase_r - sfd_pkg::PH_PAY0;
  assign word_idx = pay_pos[3:1];
  assign hunt_ph  = (rx_byte == cfg.header_byte) ? sfd_pkg::PH_FUNC : sfd_pkg::PH_HUNT;
  assign match    = (rx_byte == xor_r);

  // next phase
  always_comb begin
    case (phase_r)
      sfd_pkg::PH_HUNT: phase_nxt = hunt_ph;
      sfd_pkg::PH_FUNC: begin
        phase_nxt = (rx_byte == cfg.function_code) ? sfd_pkg::PH_SIZE : hunt_ph;
      end
      sfd_pkg::PH_SIZE: begin
        if (rx_byte == sfd_pkg::FRAME_SIZE) begin
          phase_nxt = sfd_pkg::PH_PAY0;
        end else if (cfg.function_code == cfg.header_byte) begin
          // held function byte restarts a frame as its header
          phase_nxt = (rx_byte == cfg.function_code) ? sfd_pkg::PH_SIZE : hunt_ph;
        end else begin
          phase_nxt = hunt_ph;
        end
      end
      sfd_pkg::PH_CSUM: phase_nxt = sfd_pkg::PH_HUNT;
      default:          phase_nxt = phase_r + 4'd1;
    endcase
  end

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sfd_pkg::PH_HUNT;
    end else if (byte_take) begin
      phase_r <= phase_nxt;
    end
  end

  // payload collection and running xor
  always_ff @(posedge clk) begin
    if (byte_take) begin
      if (phase_r == sfd_pkg::PH_SIZE) begin
        xor_r <= '0;
      end else if (phase_r >= sfd_pkg::PH_PAY0 && phase_r < sfd_pkg::PH_CSUM) begin
        xor_r <= xor_r ^ rx_byte;
        if (!pay_pos[0]) begin
          low_r <= rx_byte;
        end else begin
          word_r[word_idx] <= {rx_byte, low_r};
        end
      end
    end
  end

  // completed frame
  assign at_checksum = (phase_r == sfd_pkg::PH_CSUM);
  assign frame_done  = byte_take && at_checksum;

  always_comb begin
    frame.left_range     = word_r[0];
    frame.right_range    = word_r[1];
    frame.front_ball     = word_r[2];
    frame.left_ball      = word_r[3];
    frame.right_ball     = word_r[4];
    frame.rear_ball      = word_r[5];
    frame.checksum_match = match;
    frame.accepted       = !cfg.check_enable || match;
  end

endmodule

// ===== rtl/core/sensor_frame_deframer_top.sv =====
// sensor frame deframer: top level with configuration registers and result register
// depends on sfd_pkg and sfd_parser
//
// Usage:
//   in_*  : one received byte per request (in_valid / in_stall).
//   out_* : one request per complete frame with the six sensor words,
//           the checksum-match flag and the accept flag.
//   cfg_* : write port for header_byte (0), function_code (1) and
//           check_enable (2); other indexes are ignored. Write while idle.
// Throughput: one byte per cycle while in_stall is low.
// Result: the result request shows in the cycle after the checksum byte is
//   taken; bytes that end no frame give no result.
// Reset (rst_n low, synchronous): parser returns to header hunt, output
//   goes empty, registers return to 0x64, 0x01 and 0.
// Receiver stall: the result waits in the output register; bytes keep
//   flowing, and only a checksum byte is held off (in_stall) while the
//   output register is full and stalled.
module sensor_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_left_range,
  output logic [15:0] out_right_range,
  output logic [15:0] out_front_ball,
  output logic [15:0] out_left_ball,
  output logic [15:0] out_right_ball,
  output logic [15:0] out_rear_ball,
  output logic        out_checksum_match,
  output logic        out_accepted,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  sfd_pkg::cfg_t   cfg_r;
  sfd_pkg::frame_t frame;
  sfd_pkg::frame_t res_r;
  logic            out_valid_r, out_valid_nxt;
  logic            at_checksum;
  logic            frame_done;
  logic            byte_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_byte   <= sfd_pkg::HEADER_RESET;
      cfg_r.function_code <= sfd_pkg::FUNCTION_RESET;
      cfg_r.check_enable  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfd_pkg::REG_HEADER_BYTE:   cfg_r.header_byte   <= cfg_wdata;
        sfd_pkg::REG_FUNCTION_CODE: cfg_r.function_code <= cfg_wdata;
        sfd_pkg::REG_CHECK_ENABLE:  cfg_r.check_enable  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input handshake: only a frame-ending byte needs a free output slot
  assign in_stall  = at_checksum && out_valid_r && out_stall;
  assign byte_take = in_valid && !in_stall;

  sfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_take   (byte_take),
    .rx_byte     (in_rx_byte),
    .cfg         (cfg_r),
    .at_checksum (at_checksum),
    .frame_done  (frame_done),
    .frame       (frame)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (frame_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      res_r <= frame;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_range     = res_r.left_range;
  assign out_right_range    = res_r.right_range;
  assign out_front_ball     = res_r.front_ball;
  assign out_left_ball      = res_r.left_ball;
  assign out_right_ball     = res_r.right_ball;
  assign out_rear_ball      = res_r.rear_ball;
  assign out_checksum_match = res_r.checksum_match;
  assign out_accepted       = res_r.accepted;

endmodule

// ===== rtl/core/sfd_checker.sv =====
// port-level checks of the sensor frame deframer, bound to the top level
// depends on sensor_frame_deframer_top_macros.svh
`include "sensor_frame_deframer_top_macros.svh"

module sfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_left_range,
  input logic        out_accepted
);

  // a held result stays offered with its payload
  `SFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_left_range) && $stable(out_accepted))

  // input backpressure only comes from a full, stalled output
  `SFD_ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // a new result needs a byte taken the cycle before
  `SFD_ASSERT_IMPLIES(a_no_invent, clk, rst_n, out_valid && !$past(out_valid), $past(in_valid && !in_stall))

  // reset empties the output
  `SFD_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind sensor_frame_deframer_top sfd_checker u_sfd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_left_range (out_left_range),
  .out_accepted   (out_accepted)
);
